// File: hw/rtl/spd_pkg.sv
// Shared types, constants and helpers for the sorted pair distance sum block.
`timescale 1ns / 1ps
`default_nettype none

package spd_pkg;

    localparam int MAX_PAIRS = 1024;
    localparam int VALUE_W   = 32;
    localparam int COUNT_W   = $clog2(MAX_PAIRS + 1);
    localparam int TOTAL_W   = 42;
    localparam int PCOUNT_W  = 11;
    localparam int DIFF_W    = VALUE_W + 1;

    typedef logic signed [VALUE_W-1:0] value_t;
    typedef logic [COUNT_W-1:0]        count_t;

    // Per-cycle command broadcast to every cell of a chain
    typedef struct packed {
        logic insert;
        logic shift;
    } spd_ctrl_t;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_DRAIN,
        ST_DONE
    } spd_state_t;

    // Clamp the stored pair count to the width of the count port
    function automatic logic [PCOUNT_W-1:0] sat_count(input count_t cnt);
        logic [31:0] wide;
        wide = 32'(cnt);
        if (wide > 32'((1 << PCOUNT_W) - 1))
        begin
            return '1;
        end
        return wide[PCOUNT_W-1:0];
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/spd_cell.sv
// One cell of a sorted insertion chain: holds one value, trades with neighbors.
`timescale 1ns / 1ps
`default_nettype none

module spd_cell (
    input  wire logic                   clk,
    input  wire spd_pkg::spd_ctrl_t     ctrl,
    input  wire logic                   occupied,
    input  wire spd_pkg::value_t        ins_value,
    input  wire logic                   gt_prev,
    input  wire spd_pkg::value_t        prev_value,
    input  wire spd_pkg::value_t        next_value,
    output logic                        gt,
    output spd_pkg::value_t             value
);

    spd_pkg::value_t value_reg;
    spd_pkg::value_t value_next;

    // An empty cell acts as plus infinity
    assign gt = !occupied || (value_reg > ins_value);

    // Take the left neighbor's value or the new value on insert, shift down on drain
    always_comb
    begin
        value_next = value_reg;
        if (ctrl.insert && gt)
        begin
            value_next = gt_prev ? prev_value : ins_value;
        end
        else if (ctrl.shift)
        begin
            value_next = next_value;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

`default_nettype wire

// File: hw/rtl/spd_chain.sv
// Row of cells that keeps one list in ascending order and drains it from the head.
`timescale 1ns / 1ps
`default_nettype none

module spd_chain (
    input  wire logic                 clk,
    input  wire spd_pkg::spd_ctrl_t   ctrl,
    input  wire spd_pkg::count_t      count,
    input  wire spd_pkg::value_t      ins_value,
    output spd_pkg::value_t           head_value
);

    logic            gt_vec  [spd_pkg::MAX_PAIRS];
    spd_pkg::value_t val_vec [spd_pkg::MAX_PAIRS];

    for (genvar i = 0; i < spd_pkg::MAX_PAIRS; i++)
    begin : g_cell
        logic            occ;
        logic            gt_left;
        spd_pkg::value_t left_val;
        spd_pkg::value_t right_val;

        // Cells below the fill count hold live entries
        assign occ = (spd_pkg::COUNT_W'(i) < count);

        if (i == 0)
        begin : g_head
            assign gt_left  = 1'b0;
            assign left_val = ins_value;
        end
        else
        begin : g_body
            assign gt_left  = gt_vec[i-1];
            assign left_val = val_vec[i-1];
        end

        if (i == spd_pkg::MAX_PAIRS - 1)
        begin : g_tail
            assign right_val = val_vec[i];
        end
        else
        begin : g_mid
            assign right_val = val_vec[i+1];
        end

        spd_cell u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .occupied   (occ),
            .ins_value  (ins_value),
            .gt_prev    (gt_left),
            .prev_value (left_val),
            .next_value (right_val),
            .gt         (gt_vec[i]),
            .value      (val_vec[i])
        );
    end

    assign head_value = val_vec[0];

endmodule

`default_nettype wire

// File: hw/rtl/sorted_pair_distance_sum.sv
// Top level: sorted pair loading, rank-matched drain and distance accumulation.
//
// Usage: present left_value, right_value and last_pair with start high; a pair
// transfers at each rising edge where start is high and busy is low. While
// loading, busy stays low and one pair transfers every cycle: each pair is
// placed in order into two rows of cells in the cycle it arrives.
// The pair marked last is stored too, then busy rises and both rows shift out
// from their smallest entry, one rank per cycle, into an absolute-difference
// register and a 42-bit saturating accumulator. With N stored pairs, done
// rises once all N ranks are accumulated and holds for one cycle,
// carrying total_distance, pair_count and dropped; busy falls in the next cycle.
// Pairs arriving while both rows are full (1024 pairs) are discarded and flag
// dropped. The drain length is set by the number of stored pairs, one per cycle.
// The receiver cannot stall: the result is valid only while done is high.
// Reset empties both rows and clears the drop flag; no clearing pass runs.
`timescale 1ns / 1ps
`default_nettype none

module sorted_pair_distance_sum (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic signed [31:0]             left_value,
    input  wire logic signed [31:0]             right_value,
    input  wire logic                           last_pair,
    output logic                                done,
    output logic [spd_pkg::TOTAL_W-1:0]         total_distance,
    output logic [spd_pkg::PCOUNT_W-1:0]        pair_count,
    output logic                                dropped
);

    spd_pkg::spd_state_t            state_reg, state_next;
    spd_pkg::count_t                count_reg, count_next;
    spd_pkg::count_t                remain_reg, remain_next;
    logic                           ovf_reg, ovf_next;
    logic                           absv_reg, absv_next;
    logic [spd_pkg::DIFF_W-1:0]     abs_reg, abs_next;
    logic [spd_pkg::TOTAL_W-1:0]    acc_reg, acc_next;

    spd_pkg::spd_ctrl_t             ctrl;
    spd_pkg::value_t                left_head;
    spd_pkg::value_t                right_head;
    logic                           accept;
    logic                           room;
    logic signed [spd_pkg::DIFF_W-1:0] diff;
    logic [spd_pkg::TOTAL_W:0]      sum;

    assign accept = start && (state_reg == spd_pkg::ST_LOAD);
    assign room   = (count_reg < spd_pkg::COUNT_W'(spd_pkg::MAX_PAIRS));

    // Sorted rows for both lists
    spd_chain u_left (
        .clk        (clk),
        .ctrl       (ctrl),
        .count      (count_reg),
        .ins_value  (left_value),
        .head_value (left_head)
    );

    spd_chain u_right (
        .clk        (clk),
        .ctrl       (ctrl),
        .count      (count_reg),
        .ins_value  (right_value),
        .head_value (right_head)
    );

    // Signed difference of the two head cells
    assign diff = $signed({left_head[31], left_head}) - $signed({right_head[31], right_head});

    // Saturating accumulate
    assign sum = {1'b0, acc_reg} + {{(spd_pkg::TOTAL_W + 1 - spd_pkg::DIFF_W){1'b0}}, abs_reg};

    // Next state and datapath control
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        remain_next = remain_reg;
        ovf_next    = ovf_reg;
        absv_next   = 1'b0;
        abs_next    = abs_reg;
        acc_next    = acc_reg;
        ctrl        = '0;
        busy        = 1'b1;
        done        = 1'b0;

        if (absv_reg)
        begin
            acc_next = sum[spd_pkg::TOTAL_W] ? '1 : sum[spd_pkg::TOTAL_W-1:0];
        end

        case (state_reg)
            spd_pkg::ST_LOAD:
            begin
                busy = 1'b0;
                if (accept)
                begin
                    if (room)
                    begin
                        ctrl.insert = 1'b1;
                        count_next  = count_reg + 1'b1;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (last_pair)
                    begin
                        remain_next = room ? count_reg + 1'b1 : count_reg;
                        acc_next    = '0;
                        state_next  = spd_pkg::ST_DRAIN;
                    end
                end
            end
            spd_pkg::ST_DRAIN:
            begin
                if (remain_reg != '0)
                begin
                    ctrl.shift  = 1'b1;
                    absv_next   = 1'b1;
                    abs_next    = diff[spd_pkg::DIFF_W-1] ? spd_pkg::DIFF_W'(-diff)
                                                          : spd_pkg::DIFF_W'(diff);
                    remain_next = remain_reg - 1'b1;
                end
                else
                begin
                    state_next = spd_pkg::ST_DONE;
                end
            end
            spd_pkg::ST_DONE:
            begin
                done       = 1'b1;
                count_next = '0;
                ovf_next   = 1'b0;
                state_next = spd_pkg::ST_LOAD;
            end
            default:
            begin
                state_next = spd_pkg::ST_LOAD;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= spd_pkg::ST_LOAD;
            count_reg  <= '0;
            remain_reg <= '0;
            ovf_reg    <= 1'b0;
            absv_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            remain_reg <= remain_next;
            ovf_reg    <= ovf_next;
            absv_reg   <= absv_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        abs_reg <= abs_next;
        acc_reg <= acc_next;
    end

    assign total_distance = acc_reg;
    assign pair_count     = spd_pkg::sat_count(count_reg);
    assign dropped        = ovf_reg;

    // A result always covers at least one stored pair
    a_done_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (pair_count != '0))
        else $error("result with no stored pairs");

    // The last pair starts the drain
    a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && last_pair) |=> busy)
        else $error("last pair did not start drain");

    // One strobe per data set
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held longer than one cycle");

    // No difference left unaccumulated when the result shows
    a_done_flushed: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !absv_reg)
        else $error("result shown with accumulation pending");

endmodule

`default_nettype wire

// File: test/tb_top.sv
// Testbench for the sorted pair distance sum block: directed sets, capacity overflow, random sets.
`timescale 1ns / 1ps

module tb_top;

    localparam logic signed [31:0] VAL_MIN   = 32'sh8000_0000;
    localparam logic signed [31:0] VAL_MAX   = 32'sh7FFF_FFFF;
    localparam logic [63:0]        TOTAL_SAT = (64'd1 << spd_pkg::TOTAL_W) - 64'd1;
    localparam int                 COUNT_SAT = (1 << spd_pkg::PCOUNT_W) - 1;
    localparam int                 RANDOM_ITEMS = 400;

    typedef struct {
        logic [spd_pkg::TOTAL_W-1:0]  total;
        logic [spd_pkg::PCOUNT_W-1:0] count;
        logic                         dropped;
    } distance_result_t;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             start = 1'b0;
    logic signed [31:0]               left_value = '0;
    logic signed [31:0]               right_value = '0;
    logic                             last_pair = 1'b0;
    logic                             busy;
    logic                             done;
    logic [spd_pkg::TOTAL_W-1:0]      total_distance;
    logic [spd_pkg::PCOUNT_W-1:0]     pair_count;
    logic                             dropped;

    // Sorted copies of the current data set and the drop flag
    int                      left_ranked[$];
    int                      right_ranked[$];
    logic                    set_overflow = 1'b0;
    distance_result_t        expected_totals[$];
    int                      mismatches = 0;

    sorted_pair_distance_sum dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .left_value     (left_value),
        .right_value    (right_value),
        .last_pair      (last_pair),
        .done           (done),
        .total_distance (total_distance),
        .pair_count     (pair_count),
        .dropped        (dropped)
    );

    always #10 clk = ~clk;

    // Find the position that keeps the list ascending, after any equal entries
    function automatic int rank_slot(input int ranked[$], input int v);
        int pos;
        pos = ranked.size();
        while (pos > 0 && ranked[pos-1] > v)
        begin
            pos--;
        end
        return pos;
    endfunction

    // Update the set on each accepted pair; on the last pair queue the expected total
    task automatic record_pair(input logic signed [31:0] lv, input logic signed [31:0] rv,
                               input logic last);
        distance_result_t res;
        logic [63:0]      sum;
        longint           diff;
        int               n;
        if (left_ranked.size() < spd_pkg::MAX_PAIRS)
        begin
            left_ranked.insert(rank_slot(left_ranked, int'(lv)), int'(lv));
            right_ranked.insert(rank_slot(right_ranked, int'(rv)), int'(rv));
        end
        else
        begin
            set_overflow = 1'b1;
        end
        if (last)
        begin
            sum = '0;
            n = left_ranked.size();
            for (int i = 0; i < n; i++)
            begin
                diff = longint'(left_ranked[i]) - longint'(right_ranked[i]);
                if (diff < 0)
                begin
                    diff = -diff;
                end
                if (sum > TOTAL_SAT - 64'(diff))
                begin
                    sum = TOTAL_SAT;
                end
                else
                begin
                    sum = sum + 64'(diff);
                end
            end
            res.total   = sum[spd_pkg::TOTAL_W-1:0];
            res.count   = (n > COUNT_SAT) ? spd_pkg::PCOUNT_W'(COUNT_SAT)
                                          : spd_pkg::PCOUNT_W'(n);
            res.dropped = set_overflow;
            expected_totals = {expected_totals, res};
            left_ranked.delete();
            right_ranked.delete();
            set_overflow = 1'b0;
        end
    endtask

    // Drive one pair after a random gap and hold it until the transfer
    task automatic send_pair(input logic signed [31:0] lv, input logic signed [31:0] rv,
                             input logic last);
        int gap;
        gap = $urandom_range(0, 3);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start       <= 1'b1;
        left_value  <= lv;
        right_value <= rv;
        last_pair   <= last;
        do
        begin
            @(posedge clk);
        end
        while (busy);
        record_pair(lv, rv, last);
    endtask

    // Mix full-range values with near-equal values and the extremes
    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 32'(int'($urandom_range(0, 8)) - 4);
            1:
            begin
                case ($urandom_range(0, 3))
                    0: return VAL_MIN;
                    1: return VAL_MAX;
                    2: return 32'sd0;
                    default: return -32'sd1;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    // Check each result strobe against the oldest expected total
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_totals.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("ERROR: unexpected result total=%0d count=%0d dropped=%0b",
                             total_distance, pair_count, dropped);
                end
            end
            else
            begin
                distance_result_t exp_res;
                exp_res = expected_totals.pop_front();
                if (total_distance !== exp_res.total || pair_count !== exp_res.count ||
                    dropped !== exp_res.dropped)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("ERROR: total exp %0d got %0d, count exp %0d got %0d, %s",
                                 exp_res.total, total_distance, exp_res.count, pair_count,
                                 $sformatf("dropped exp %0b got %0b",
                                           exp_res.dropped, dropped));
                    end
                end
            end
        end
    end

    // Single-pair sets at the extremes of the value range
    task automatic test_single_pairs();
        send_pair(VAL_MIN, VAL_MAX, 1'b1);
        send_pair(VAL_MAX, VAL_MIN, 1'b1);
        send_pair(32'sd0, 32'sd0, 1'b1);
        send_pair(-32'sd1, 32'sd1, 1'b1);
    endtask

    // Out-of-order and tied inserts, then a set of equal pairs
    task automatic test_ties_and_order();
        send_pair(32'sd5, VAL_MIN, 1'b0);
        send_pair(32'sd5, 32'sd5, 1'b0);
        send_pair(-32'sd3, 32'sd5, 1'b0);
        send_pair(VAL_MAX, 32'sd0, 1'b0);
        send_pair(VAL_MIN, -32'sd3, 1'b1);
        repeat (3) send_pair(32'sd7, 32'sd7, 1'b0);
        send_pair(32'sd7, 32'sd7, 1'b1);
    endtask

    // Fill both stores, overflow them, close on a dropped pair, then a fresh set
    task automatic test_capacity_overflow();
        for (int i = 0; i < spd_pkg::MAX_PAIRS + 2; i++)
        begin
            send_pair(VAL_MIN, VAL_MAX, 1'b0);
        end
        send_pair(32'sd1, 32'sd2, 1'b1);
        send_pair(32'sd100, -32'sd100, 1'b1);
    endtask

    // Random sets, mostly short with an occasional longer one
    task automatic test_random_sets();
        int sent;
        int set_len;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            set_len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40)
                                                  : $urandom_range(1, 8);
            for (int i = 0; i < set_len; i++)
            begin
                send_pair(pick_value(), pick_value(), i == set_len - 1);
            end
            sent += set_len;
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_single_pairs();
        test_ties_and_order();
        test_capacity_overflow();
        test_random_sets();
        start <= 1'b0;
        // Wait for the last drain, then allow for one full drain more
        while (expected_totals.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (spd_pkg::MAX_PAIRS + 8) @(posedge clk);
        if (mismatches == 0 && expected_totals.size() == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

    // Stop a hung run
    initial
    begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/spd_pkg.sv
hw/rtl/spd_cell.sv
hw/rtl/spd_chain.sv
hw/rtl/sorted_pair_distance_sum.sv
test/tb_top.sv
